// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Triggered capture buffer package
// Constants, command and status types shared by the capture buffer modules.
// ----------------------------------------------------------------------------
package tcb_pkg;

  localparam int Depth  = 64;
  localparam int AddrW  = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);
  localparam int DataW  = 8;
  localparam int MissW  = 9;
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [DataW-1:0] WindowReset = 8'd2;
  localparam logic [DataW-1:0] LimitReset  = 8'd10;

  typedef enum logic {
    FuncSample = 1'b0,
    FuncSend   = 1'b1
  } func_e;

  typedef enum logic {
    RegTrigWindow = 1'b0,
    RegResyncLimit = 1'b1
  } reg_idx_e;

  // One unit of work for the back end: an optional store write, an optional
  // dump that precedes the write, and the indicator values to report.
  typedef struct packed {
    logic             dump;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [DataW-1:0] wr_data;
    logic             capture;
    logic             resync;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic dumping;
  } back_ctl_t;

endpackage

// ===== sv/tcb_ifs.sv =====
// ----------------------------------------------------------------------------
// Capture buffer channels
// Valid/ready channels for sample words in and result words out.
// ----------------------------------------------------------------------------
interface tcb_in_if;
  import tcb_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [DataW-1:0] sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink (input valid, input func, input sample, output ready);
endinterface

interface tcb_out_if;
  import tcb_pkg::*;

  logic             valid;
  logic             ready;
  logic             has_data;
  logic [DataW-1:0] data_byte;
  logic             last;
  logic             capture_led;
  logic             resync_led;

  modport source (output valid, output has_data, output data_byte, output last,
                  output capture_led, output resync_led, input ready);
  modport sink (input valid, input has_data, input data_byte, input last,
                input capture_led, input resync_led, output ready);
endinterface

// ===== sv/triggered_capture_buffer_core.sv =====
// ----------------------------------------------------------------------------
// Triggered capture buffer core
// Level-triggered capture of eight-bit samples with dump on request.
// ----------------------------------------------------------------------------
// Words enter on samp_i: func low carries a converter sample, func high is a
// send request. Every word yields one result word on res_o, except a sample
// that finds the store full while a send request is pending: it yields the
// whole store of 64 samples, oldest first, with last set on the final one.
// The APB port holds the trigger window (address 0, reset 2) and the resync
// limit (address 4, reset 10); write them only while the block is idle.
// A plain result passes the command queue and result register; a dump first
// passes its start step and the store read register. Each end moves one word per
// cycle unless held by a full queue or the receiver; a dump holds the back end for
// a start step and 64 words, so the two-entry command queue fills and samp_i.ready drops.
// Reset clears the fill level, trigger level, miss counter and indicators;
// the store contents are undefined until written and are never read before.
// If the receiver stalls, the result register holds its word, the queue
// fills and input stops; nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triggered_capture_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcb_in_if.sink      samp_i,
  tcb_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcb_pkg::*;

  logic [DataW-1:0] trig_window_q;
  logic [DataW-1:0] resync_limit_q;
  logic             cfg_we;

  logic             q_push;
  cmd_t             q_cmd_in;
  cmd_t             q_cmd_out;
  q_stat_t          q_stat;
  back_ctl_t        back_ctl;

  // Configuration registers. The register is picked by the word address bit.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_window_q  <= WindowReset;
      resync_limit_q <= LimitReset;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[2]))
        RegTrigWindow:  trig_window_q  <= pwdata[DataW-1:0];
        RegResyncLimit: resync_limit_q <= pwdata[DataW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      RegTrigWindow:  prdata = {{(32-DataW){1'b0}}, trig_window_q};
      RegResyncLimit: prdata = {{(32-DataW){1'b0}}, resync_limit_q};
      default:        prdata = '0;
    endcase
  end

  // The front end decides what each word does; the back end replays those
  // decisions in order against the sample store.
  tcb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .samp_i         (samp_i),
    .trig_window_i  (trig_window_q),
    .resync_limit_i (resync_limit_q),
    .q_stat_i       (q_stat),
    .push_o         (q_push),
    .cmd_o          (q_cmd_in)
  );

  tcb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .pop_i  (back_ctl.pop),
    .cmd_o  (q_cmd_out),
    .stat_o (q_stat)
  );

  tcb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (q_cmd_out),
    .q_stat_i (q_stat),
    .ctl_o    (back_ctl),
    .res_o    (res_o)
  );

  `TCB_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "push into full queue")
  `TCB_ASSERT_IMP(a_no_pop_empty, back_ctl.pop, !q_stat.empty, "pop from empty queue")
  `TCB_ASSERT_IMP(a_dump_starts_pop, $rose(back_ctl.dumping), $past(back_ctl.pop), "dump without pop")
  `TCB_ASSERT_NXT(a_push_fills, q_push && !back_ctl.pop, !q_stat.empty, "queue lost a word")

endmodule

// ===== sv/tcb_front.sv =====
// ----------------------------------------------------------------------------
// Capture buffer front end
// Accepts words, tracks fill level and trigger state, and issues commands.
// ----------------------------------------------------------------------------
module tcb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tcb_in_if.sink                 samp_i,
  input  logic [tcb_pkg::DataW-1:0] trig_window_i,
  input  logic [tcb_pkg::DataW-1:0] resync_limit_i,
  input  tcb_pkg::q_stat_t       q_stat_i,
  output logic                   push_o,
  output tcb_pkg::cmd_t          cmd_o
);
  import tcb_pkg::*;

  logic [CntW-1:0]  widx_q, widx_d;
  logic [DataW-1:0] level_q, level_d;
  logic [MissW-1:0] miss_q, miss_d;
  logic             send_q, send_d;
  logic             capture_q, capture_d;
  logic             resync_q, resync_d;
  logic [DataW-1:0] diff;
  logic [MissW-1:0] miss_inc;
  cmd_t             cmd;

  assign samp_i.ready = !q_stat_i.full;
  assign push_o       = samp_i.valid && !q_stat_i.full;
  assign cmd_o        = cmd;

  always_comb begin
    widx_d    = widx_q;
    level_d   = level_q;
    miss_d    = miss_q;
    send_d    = send_q;
    capture_d = capture_q;
    resync_d  = resync_q;
    cmd       = '0;
    diff      = (samp_i.sample >= level_q) ? (samp_i.sample - level_q)
                                           : (level_q - samp_i.sample);
    miss_inc  = miss_q + MissW'(1);
    if (push_o) begin
      if (func_e'(samp_i.func) == FuncSend) begin
        send_d = 1'b1;
      end else begin
        capture_d = 1'b0;
        if (widx_q < CntW'(Depth)) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = widx_q[AddrW-1:0];
          widx_d      = widx_q + CntW'(1);
        end else begin
          cmd.dump = send_q;
          send_d   = 1'b0;
          if (diff < trig_window_i) begin
            // Match: capture restarts with this sample as the oldest entry.
            capture_d   = 1'b1;
            resync_d    = 1'b0;
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = '0;
            widx_d      = CntW'(1);
          end else if (miss_inc > {1'b0, resync_limit_i}) begin
            level_d  = samp_i.sample;
            miss_d   = '0;
            resync_d = 1'b1;
          end else begin
            miss_d = miss_inc;
          end
        end
      end
      cmd.wr_data = samp_i.sample;
      cmd.capture = capture_d;
      cmd.resync  = resync_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q    <= '0;
      level_q   <= '0;
      miss_q    <= '0;
      send_q    <= 1'b0;
      capture_q <= 1'b0;
      resync_q  <= 1'b0;
    end else begin
      widx_q    <= widx_d;
      level_q   <= level_d;
      miss_q    <= miss_d;
      send_q    <= send_d;
      capture_q <= capture_d;
      resync_q  <= resync_d;
    end
  end

endmodule

// ===== sv/tcb_queue.sv =====
// ----------------------------------------------------------------------------
// Capture buffer command queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module tcb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tcb_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output tcb_pkg::cmd_t      cmd_o,
  output tcb_pkg::q_stat_t   stat_o
);
  import tcb_pkg::*;

  cmd_t             slot_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign cmd_o        = slot_q[rptr_q];
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/tcb_back.sv =====
// ----------------------------------------------------------------------------
// Capture buffer back end
// Owns the sample store, plays out dumps and drives the result register.
// ----------------------------------------------------------------------------
module tcb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcb_pkg::cmd_t        cmd_i,
  input  tcb_pkg::q_stat_t     q_stat_i,
  output tcb_pkg::back_ctl_t   ctl_o,
  tcb_out_if.source            res_o
);
  import tcb_pkg::*;

  typedef enum logic {
    StIdle,
    StDump
  } state_e;

  logic [DataW-1:0] store [Depth];
  logic [DataW-1:0] rd_data_q;

  state_e           state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  cmd_t             cur_q, cur_d;
  logic             ovalid_q, ovalid_d;
  logic             ohas_q, ohas_d;
  logic [DataW-1:0] odata_q, odata_d;
  logic             olast_q, olast_d;
  logic             ocap_q, ocap_d;
  logic             ores_q, ores_d;

  logic             slot_free;
  logic             pop;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [DataW-1:0] wdata;

  assign slot_free = !ovalid_q || res_o.ready;

  assign res_o.valid       = ovalid_q;
  assign res_o.has_data    = ohas_q;
  assign res_o.data_byte   = odata_q;
  assign res_o.last        = olast_q;
  assign res_o.capture_led = ocap_q;
  assign res_o.resync_led  = ores_q;

  assign ctl_o.pop     = pop;
  assign ctl_o.dumping = (state_q == StDump);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    ovalid_d = ovalid_q && !res_o.ready;
    ohas_d   = ohas_q;
    odata_d  = odata_q;
    olast_d  = olast_q;
    ocap_d   = ocap_q;
    ores_d   = ores_q;
    pop      = 1'b0;
    we       = 1'b0;
    waddr    = cmd_i.wr_addr;
    wdata    = cmd_i.wr_data;
    case (state_q)
      StIdle: begin
        if (!q_stat_i.empty && slot_free) begin
          pop = 1'b1;
          if (cmd_i.dump) begin
            state_d = StDump;
            idx_d   = '0;
            cur_d   = cmd_i;
          end else begin
            we       = cmd_i.wr_en;
            ovalid_d = 1'b1;
            ohas_d   = 1'b0;
            odata_d  = '0;
            olast_d  = 1'b1;
            ocap_d   = cmd_i.capture;
            ores_d   = cmd_i.resync;
          end
        end
      end
      StDump: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ohas_d   = 1'b1;
          odata_d  = rd_data_q;
          olast_d  = (idx_q == AddrW'(Depth - 1));
          ocap_d   = cur_q.capture;
          ores_d   = cur_q.resync;
          if (idx_q == AddrW'(Depth - 1)) begin
            // The restart write lands only after the old entry 0 was read.
            state_d = StIdle;
            we      = cur_q.wr_en;
            waddr   = cur_q.wr_addr;
            wdata   = cur_q.wr_data;
          end else begin
            idx_d = idx_q + AddrW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ohas_q  <= ohas_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    ocap_q  <= ocap_d;
    ores_q  <= ores_d;
  end

  // Read address follows the next dump index, so during a dump rd_data_q holds
  // the entry at idx_q.
  always_ff @(posedge clk_i) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rd_data_q <= store[idx_d];
  end

endmodule

// ===== test/triggered_capture_buffer_core_test.sv =====
// ----------------------------------------------------------------------------
// Triggered capture buffer core testbench
// Drives sample and send-request words into the core and checks every result
// word against a cycle-free model of the capture store, trigger level, miss
// counter and dump logic. Covers register extremes, receiver stalls and
// several idle patterns on both channels.
// ----------------------------------------------------------------------------
module triggered_capture_buffer_core_test;
  import tcb_pkg::*;

  // One result word as seen on the result channel.
  typedef struct packed {
    logic             has_data;
    logic [DataW-1:0] data_byte;
    logic             last;
    logic             capture_led;
    logic             resync_led;
  } res_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tcb_in_if  samp_if ();
  tcb_out_if res_if ();

  triggered_capture_buffer_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .samp_i  (samp_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the core's state. It is advanced once per accepted word, so
  // stimulus that is built from it always sees every earlier word applied.
  logic [DataW-1:0] m_store [Depth];
  logic [6:0]       m_wr_idx    = '0;
  logic [DataW-1:0] m_level     = '0;
  logic [MissW-1:0] m_miss      = '0;
  logic             m_send_pend = 1'b0;
  logic             m_capture   = 1'b0;
  logic             m_resync    = 1'b0;
  logic [DataW-1:0] m_window    = WindowReset;
  logic [DataW-1:0] m_limit     = LimitReset;
  int               adopt_count = 0;

  // Result words that the core still owes, oldest first.
  res_word_t owed_words [$];

  int errors      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold     = 1'b0;

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void check_field(string name, int unsigned want, logic [7:0] got);
    if (got !== 8'(want))
      note_error($sformatf("%s: expected %0d, got %0d", name, want, got));
  endfunction

  function automatic void owe_word(logic has, logic [DataW-1:0] data, logic last);
    res_word_t w;
    w = '{has, data, last, m_capture, m_resync};
    owed_words.push_back(w);
  endfunction

  // Applies one accepted word to the mirror and queues the result words it
  // causes. A dump reports the store as it was before a restart, with the
  // indicator values that this sample leaves behind.
  function automatic void advance_capture(func_e f, logic [DataW-1:0] s);
    logic             dump;
    logic [DataW-1:0] diff;
    dump = 1'b0;
    if (f == FuncSend) begin
      m_send_pend = 1'b1;
      owe_word(1'b0, '0, 1'b1);
      return;
    end
    m_capture = 1'b0;
    if (m_wr_idx < Depth) begin
      m_store[m_wr_idx[AddrW-1:0]] = s;
      m_wr_idx = m_wr_idx + 7'd1;
    end else begin
      if (m_send_pend) begin
        m_send_pend = 1'b0;
        dump = 1'b1;
      end
      diff = (s >= m_level) ? s - m_level : m_level - s;
      if (diff < m_window) begin
        m_capture = 1'b1;
        m_resync = 1'b0;
      end else begin
        m_miss = m_miss + 9'd1;
        if (m_miss > {1'b0, m_limit}) begin
          m_level = s;
          m_miss = '0;
          m_resync = 1'b1;
          adopt_count++;
        end
      end
      if (dump) begin
        for (int i = 0; i < Depth; i++) owe_word(1'b1, m_store[i], i == Depth - 1);
      end
      if (m_capture) begin
        m_store[0] = s;
        m_wr_idx = 7'd1;
      end
    end
    if (!dump) owe_word(1'b0, '0, 1'b1);
  endfunction

  // Receiver: ready is redrawn every cycle unless a long hold-off is active.
  always @(negedge clk_i) begin
    res_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Every accepted result word is matched against the oldest owed word.
  always @(posedge clk_i) begin : check_words
    res_word_t got;
    res_word_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.has_data, res_if.data_byte, res_if.last,
              res_if.capture_led, res_if.resync_led};
      if (owed_words.size() == 0) begin
        note_error($sformatf("result word with nothing owed: %p", got));
      end else begin
        want = owed_words.pop_front();
        check_field("has_data", want.has_data, got.has_data);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("last", want.last, got.last);
        check_field("capture_led", want.capture_led, got.capture_led);
        check_field("resync_led", want.resync_led, got.resync_led);
      end
    end
  end

  // Offers one word, with random gaps before it, and returns at the edge
  // where it is accepted. Valid stays high afterwards, so whoever stops
  // sending must lower it through wait_drained.
  task automatic send_word(input func_e f, input logic [DataW-1:0] s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      samp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    samp_if.valid  <= 1'b1;
    samp_if.func   <= f;
    samp_if.sample <= s;
    do @(posedge clk_i); while (!samp_if.ready);
    advance_capture(f, s);
  endtask

  // Stops offering words and waits until every owed result word has come.
  // Every word causes a result, so the core is idle afterwards.
  task automatic wait_drained();
    @(negedge clk_i);
    samp_if.valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_xfer(input logic wr, input reg_idx_e idx,
                          input logic [7:0] wdata, output logic [7:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 3'(int'(idx) << 2);
    pwdata  <= {24'd0, wdata};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata[7:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a register, updates the mirror and reads the value back.
  task automatic write_reg(input reg_idx_e idx, input logic [7:0] value);
    logic [7:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    if (idx == RegTrigWindow) m_window = value;
    else m_limit = value;
    apb_xfer(1'b0, idx, 8'd0, rd);
    check_field($sformatf("readback of %s", idx.name()), value, rd);
  endtask

  // While the store is full, a good share of samples land near the trigger
  // level so that both sides of the window boundary are hit.
  function automatic logic [DataW-1:0] pick_sample();
    int off;
    off = int'($urandom_range(0, 2 * m_window)) - int'(m_window);
    if (m_wr_idx == Depth && $urandom_range(0, 9) < 4) return 8'(int'(m_level) + off);
    return 8'($urandom);
  endfunction

  task automatic fill_store();
    while (m_wr_idx < Depth) send_word(FuncSample, 8'($urandom));
  endtask

  task automatic test_reset_values();
    logic [7:0] rd;
    apb_xfer(1'b0, RegTrigWindow, 8'd0, rd);
    check_field("trigger_window after reset", WindowReset, rd);
    apb_xfer(1'b0, RegResyncLimit, 8'd0, rd);
    check_field("resync_limit after reset", LimitReset, rd);
  endtask

  task automatic test_directed();
    int adopted;
    tx_idle_pct = 17;
    rx_idle_pct = 75;
    // A request before the store is full is held; a second one changes nothing.
    send_word(FuncSend, 8'h00);
    send_word(FuncSend, 8'hFF);
    send_word(FuncSample, 8'h00);
    send_word(FuncSample, 8'hFF);
    send_word(FuncSample, 8'h55);
    send_word(FuncSample, 8'hAA);
    fill_store();
    // Level 0, window 2: a difference equal to the window is a miss. This
    // sample also releases the pending dump.
    send_word(FuncSample, 8'd2);
    send_word(FuncSample, 8'hFF);
    // Keep missing until the miss counter passes the limit and the core
    // adopts a new trigger level.
    adopted = adopt_count;
    while (adopt_count == adopted) send_word(FuncSample, 8'h80);
    wait_drained();
    // A zero window never matches, not even the exact trigger level.
    write_reg(RegTrigWindow, 8'd0);
    send_word(FuncSample, m_level);
    wait_drained();
    // With a zero limit the first miss adopts the sample as the new level.
    write_reg(RegResyncLimit, 8'd0);
    send_word(FuncSample, m_level ^ 8'h01);
    send_word(FuncSend, 8'h5A);
    send_word(FuncSample, m_level ^ 8'hA5);
    wait_drained();
  endtask

  task automatic random_phase(input int n, input int tx, input int rx,
                              input logic [7:0] win, input logic [7:0] lim);
    wait_drained();
    write_reg(RegTrigWindow, win);
    write_reg(RegResyncLimit, lim);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    repeat (n) begin
      if ($urandom_range(0, 99) < 8) send_word(FuncSend, 8'($urandom));
      else send_word(FuncSample, pick_sample());
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while a dump is owed and the
  // sender keeps offering, so the command queue fills and input stalls.
  // Afterwards the sender pauses until every owed word has come.
  task automatic test_stalled_receiver();
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fill_store();
    send_word(FuncSend, 8'($urandom));
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(negedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    repeat (10) send_word(FuncSample, pick_sample());
    wait_drained();
    fill_store();
    send_word(FuncSend, 8'($urandom));
    repeat (10) send_word(FuncSample, pick_sample());
    wait_drained();
  endtask

  // With the store full and a window of two, a sample one away from the
  // level matches: capture restarts and the resync indicator clears. The
  // next sample drops the capture indicator again.
  task automatic test_window_match();
    wait_drained();
    write_reg(RegTrigWindow, 8'd2);
    fill_store();
    send_word(FuncSample, m_level ^ 8'h01);
    send_word(FuncSample, m_level);
    wait_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    samp_if.valid  = 1'b0;
    samp_if.func   = FuncSample;
    samp_if.sample = '0;
    for (int i = 0; i < Depth; i++) m_store[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_directed();
    random_phase(30, 75, 17, 8'd0, 8'd3);
    test_stalled_receiver();
    test_window_match();
    random_phase(40, 0, 0, 8'd40, 8'd20);

    // Give any stray word from the core time to show up.
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && owed_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
